/* hdl/sirt_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and types for the signed integer to radix text block
// no dependencies

package sirt_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_RADIX  = 16;
    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = $clog2(MAX_RADIX);
    localparam int SYM_W      = 8;
    localparam int NUM_SYMS   = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = $clog2(VALUE_BITS);

    // divider consumes this many dividend bits per cycle
    localparam int STEP_BITS  = 8;
    localparam int NUM_STEPS  = VALUE_BITS / STEP_BITS;
    localparam int STEP_W     = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX    = 2'd0,
        CFG_SYMS_LO  = 2'd1,
        CFG_SYMS_HI  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIGIT_W-1:0]    remainder;
    } t_div_stat;

endpackage

/* hdl/signed_integer_to_radix_text_core.sv */
`timescale 1ns / 1ps
// top level of the signed integer to radix text converter
// depends on sirt_pkg and sirt_divider
//
// usage
//   input channel: i_valid / i_value, stall back on o_stall; a transfer happens
//   on a rising edge with i_valid high and o_stall low. o_stall is high for the
//   whole conversion, one number is in flight at a time.
//   output channel: o_valid / o_symbol / o_last, stall from i_stall. one symbol
//   byte per transfer, most significant first, a minus symbol ahead of the
//   digits of a negative number, o_last on the final digit.
//   config: i_cfg_we / i_cfg_idx / i_cfg_data, radix at index 0, symbols 0..7 at
//   index 1, symbols 8..15 at index 2. write only while the block is idle.
//   a table that is invalid (radix below 2 or above 16, a plus or minus symbol
//   or a repeated symbol among the first radix entries) drops the number.
// sequence
//   a table check first, then each digit in the shared divider (4 chunk steps
//   of 8 bits plus a restart), then one symbol per cycle into the output
//   register while the output is not stalled. a number has at most 32 digits.
//   the next number is taken once the last symbol sits in the output register.
// reset
//   synchronous, active low: config clears to zero, control goes idle, output
//   register empties. an output stall holds the symbol and, while emitting, the sequencer.

module signed_integer_to_radix_text_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // number input
    input  logic                                   i_valid,
    input  logic signed [sirt_pkg::VALUE_BITS-1:0] i_value,
    output logic                                   o_stall,
    // symbol output
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [sirt_pkg::SYM_W-1:0]             o_symbol,
    output logic                                   o_last,
    // config writes
    input  logic                                   i_cfg_we,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [sirt_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    // config registers
    logic [sirt_pkg::RADIX_W-1:0]    r_radix;
    logic [sirt_pkg::CFG_DATA_W-1:0] r_syms_lo;
    logic [sirt_pkg::CFG_DATA_W-1:0] r_syms_hi;

    // sequencer and conversion state
    sirt_pkg::t_state                r_state, n_state;
    logic                            r_neg;
    logic [sirt_pkg::VALUE_BITS-1:0] r_mag;
    logic [sirt_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [sirt_pkg::CNT_W-1:0]      r_pos, n_pos;
    logic                            r_minus, n_minus;
    logic [sirt_pkg::DIGIT_W-1:0]    r_digits [sirt_pkg::VALUE_BITS];
    // digit at r_pos, registered from the store at the next value of the position
    logic [sirt_pkg::DIGIT_W-1:0]    r_dig_rd;

    // output register
    logic                            n_valid;
    logic [sirt_pkg::SYM_W-1:0]      n_symbol;
    logic                            n_last;

    sirt_pkg::t_div_req              div_req;
    sirt_pkg::t_div_stat             div_stat;

    logic [sirt_pkg::SYM_W-1:0]      syms [sirt_pkg::NUM_SYMS];
    logic                            table_ok;
    logic                            in_xfer;
    logic                            out_free;
    logic                            digit_wr;
    logic                            div_more;

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;
    assign o_stall  = (r_state != sirt_pkg::ST_IDLE);

    // unpack the symbol table
    always_comb begin
        for (int i = 0; i < sirt_pkg::NUM_SYMS; i++) begin
            if (i < 8) begin
                syms[i] = r_syms_lo[i*sirt_pkg::SYM_W +: sirt_pkg::SYM_W];
            end else begin
                syms[i] = r_syms_hi[(i-8)*sirt_pkg::SYM_W +: sirt_pkg::SYM_W];
            end
        end
    end

    // table check: radix range, no sign symbols, no duplicates among used entries
    always_comb begin
        table_ok = (r_radix >= sirt_pkg::RADIX_W'(2)) &&
                   (r_radix <= sirt_pkg::RADIX_W'(sirt_pkg::MAX_RADIX));
        for (int i = 0; i < sirt_pkg::NUM_SYMS; i++) begin
            if (sirt_pkg::RADIX_W'(i) < r_radix) begin
                if (syms[i] == sirt_pkg::SYM_MINUS || syms[i] == sirt_pkg::SYM_PLUS) begin
                    table_ok = 1'b0;
                end
                for (int j = 0; j < i; j++) begin
                    if (syms[j] == syms[i]) begin
                        table_ok = 1'b0;
                    end
                end
            end
        end
    end

    // another digit needed when the quotient is nonzero and the store has room
    assign div_more = (div_stat.quotient != '0) &&
                      (r_cnt != sirt_pkg::CNT_W'(sirt_pkg::VALUE_BITS - 1));
    assign digit_wr = (r_state == sirt_pkg::ST_DIV) && div_stat.done;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_mag;
        if (r_state == sirt_pkg::ST_CHECK) begin
            div_req.start = table_ok;
        end else if (digit_wr && div_more) begin
            div_req.start    = 1'b1;
            div_req.dividend = div_stat.quotient;
        end
    end

    sirt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_radix (r_radix),
        .o_stat  (div_stat)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_minus  = r_minus;
        n_valid  = o_valid;
        n_symbol = o_symbol;
        n_last   = o_last;

        // output register drains on a transfer
        if (o_valid && !i_stall) begin
            n_valid = 1'b0;
        end

        case (r_state)
            sirt_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = sirt_pkg::ST_CHECK;
                end
            end
            sirt_pkg::ST_CHECK: begin
                n_cnt = '0;
                if (table_ok) begin
                    n_state = sirt_pkg::ST_DIV;
                end else begin
                    // bad table: number dropped, nothing emitted
                    n_state = sirt_pkg::ST_IDLE;
                end
            end
            sirt_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    if (div_more) begin
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        // r_cnt is the index of the top digit
                        n_pos   = r_cnt;
                        n_minus = r_neg;
                        n_state = sirt_pkg::ST_EMIT;
                    end
                end
            end
            sirt_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    if (r_minus) begin
                        n_symbol = sirt_pkg::SYM_MINUS;
                        n_last   = 1'b0;
                        n_minus  = 1'b0;
                    end else begin
                        n_symbol = syms[r_dig_rd];
                        n_last   = (r_pos == '0);
                        if (r_pos == '0) begin
                            n_state = sirt_pkg::ST_IDLE;
                        end else begin
                            n_pos = r_pos - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = sirt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sirt_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_pos     <= '0;
            r_minus   <= 1'b0;
            r_neg     <= 1'b0;
            o_valid   <= 1'b0;
            r_radix   <= '0;
            r_syms_lo <= '0;
            r_syms_hi <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_minus <= n_minus;
            o_valid <= n_valid;
            if (in_xfer) begin
                r_neg <= i_value[sirt_pkg::VALUE_BITS-1];
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sirt_pkg::CFG_RADIX:   r_radix   <= i_cfg_data[sirt_pkg::RADIX_W-1:0];
                    sirt_pkg::CFG_SYMS_LO: r_syms_lo <= i_cfg_data;
                    sirt_pkg::CFG_SYMS_HI: r_syms_hi <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        o_symbol <= n_symbol;
        o_last   <= n_last;
        if (in_xfer) begin
            // two's complement magnitude, most negative value maps onto itself
            r_mag <= i_value[sirt_pkg::VALUE_BITS-1] ? (~$unsigned(i_value) + 1'b1)
                                                      : $unsigned(i_value);
        end
        if (digit_wr) begin
            r_digits[r_cnt] <= div_stat.remainder;
        end
        // the top digit is written on the same edge that points r_pos at it
        if (digit_wr && (n_pos == r_cnt)) begin
            r_dig_rd <= div_stat.remainder;
        end else begin
            r_dig_rd <= r_digits[n_pos];
        end
    end

endmodule

/* hdl/sirt_divider.sv */
`timescale 1ns / 1ps
// iterative divider of the magnitude by the radix, STEP_BITS quotient bits per cycle
// depends on sirt_pkg

module sirt_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sirt_pkg::t_div_req                  i_req,
    input  logic [sirt_pkg::RADIX_W-1:0]        i_radix,
    output sirt_pkg::t_div_stat                 o_stat
);

    logic [sirt_pkg::VALUE_BITS-1:0] r_quo, n_quo;
    logic [sirt_pkg::DIGIT_W-1:0]    r_rem, n_rem;
    logic [sirt_pkg::STEP_W-1:0]     r_step;
    logic                            r_run;
    logic                            r_done;

    logic [sirt_pkg::STEP_BITS-1:0]  chunk;
    logic [sirt_pkg::STEP_BITS-1:0]  qbits;

    // restoring division over one chunk, remainder stays below the radix
    always_comb begin
        logic [sirt_pkg::RADIX_W-1:0] t;
        logic [sirt_pkg::DIGIT_W-1:0] rem;
        chunk = r_quo[sirt_pkg::VALUE_BITS-1 -: sirt_pkg::STEP_BITS];
        rem   = r_rem;
        qbits = '0;
        t     = '0;
        for (int b = sirt_pkg::STEP_BITS - 1; b >= 0; b--) begin
            t = sirt_pkg::RADIX_W'({rem, chunk[b]});
            if (t >= i_radix) begin
                t        = t - i_radix;
                qbits[b] = 1'b1;
            end
            rem = t[sirt_pkg::DIGIT_W-1:0];
        end
        n_rem = rem;
        n_quo = (r_quo << sirt_pkg::STEP_BITS) | sirt_pkg::VALUE_BITS'(qbits);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_run) begin
            r_step <= r_step + 1'b1;
            if (r_step == sirt_pkg::STEP_W'(sirt_pkg::NUM_STEPS - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
        end else if (r_run) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.quotient  = r_quo;
    assign o_stat.remainder = r_rem;

endmodule

/* hdl/sirt_checker.sv */
`timescale 1ns / 1ps
// port level checks for the radix text converter, bound to the top level
// depends on sirt_pkg and signed_integer_to_radix_text_core

module sirt_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_stall,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic [sirt_pkg::SYM_W-1:0]             o_symbol,
    input logic                                   o_last
);

    // output register empties on reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled symbol holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_symbol) && $stable(o_last))
        else $error("stalled output changed");

    // one number at a time: a taken input closes the input channel
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input open right after a transfer");

    // the minus symbol always leads digits, never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_symbol == sirt_pkg::SYM_MINUS) |-> !o_last)
        else $error("minus symbol marked last");

endmodule

bind signed_integer_to_radix_text_core sirt_checker u_sirt_checker (.*);
